/* hw/rtl/irpwd_pkg.sv */
// Package: shared types, codes and duration compare helpers for the IR pulse-width decoder.
`default_nettype none

package irpwd_pkg;

  // Field widths
  localparam int unsigned TolW   = 12;
  localparam int unsigned DurW   = 16;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 9;
  localparam int unsigned CfgAw  = 3;
  localparam int unsigned CfgDw  = 16;
  localparam int unsigned InDw   = 8;
  localparam int unsigned OutDw  = 48;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_NOISE     = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic [CfgAw-1:0] {
    CFG_TOLERANCE    = 3'd0,
    CFG_TIMEOUT      = 3'd1,
    CFG_HEADER_MARK  = 3'd2,
    CFG_HEADER_SPACE = 3'd3,
    CFG_SKIP_LENGTH  = 3'd4,
    CFG_ZERO_SPACE   = 3'd5,
    CFG_ONE_SPACE    = 3'd6
  } cfg_idx_e;

  // One result item
  typedef struct packed {
    logic [CountW-1:0] reading_count;
    status_e           status;
    logic [CodeW-1:0]  code;
  } result_t;

  // |expect - dur| < tol
  function automatic logic dur_near(input logic [DurW-1:0] expect_dur,
                                    input logic [DurW:0]   dur,
                                    input logic [TolW-1:0] tol);
    logic [DurW:0] ext;
    logic [DurW:0] diff;
    begin
      ext  = {1'b0, expect_dur};
      diff = (dur >= ext) ? (dur - ext) : (ext - dur);
      dur_near = diff < {{(DurW+1-TolW){1'b0}}, tol};
    end
  endfunction

  // dur inside [centre - tol (floored at 0), centre + tol]
  function automatic logic dur_in_window(input logic [DurW-1:0] centre,
                                         input logic [DurW:0]   dur,
                                         input logic [TolW-1:0] tol);
    logic [DurW-1:0] tol_ext;
    logic [DurW-1:0] lo;
    logic [DurW:0]   hi;
    begin
      tol_ext = {{(DurW-TolW){1'b0}}, tol};
      lo      = (centre > tol_ext) ? (centre - tol_ext) : '0;
      hi      = {1'b0, centre} + {1'b0, tol_ext};
      dur_in_window = (dur >= {1'b0, lo}) && (dur <= hi);
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ir_pulse_width_decoder_top.sv */
// Top level: IR pulse-width decoder, one pin sample per item, one result per burst.
//
//  Channel   Dir  Payload (low bit up)                       Handshake
//  s_axis    in   tdata[0] pin_level, [7:1] zero             tvalid/tready
//  m_axis    out  code[31:0] status[33:32] count[42:34]      tvalid/tready
//  cfg       in   cfg_addr_i index, cfg_wdata_i value        cfg_we_i, no wait
//
//  One input item per clock while s_axis_tready_o is high; the item that ends a burst
//  pushes its result to the output slots. Per-item work is adds and a few 17-bit compares.
//  Results go to a two-slot output (result register plus skid register);
//  s_axis_tready_o drops only while both slots hold results.
//  Reset clears all burst state and loads register defaults.
`default_nettype none

module ir_pulse_width_decoder_top #(
  parameter int unsigned MAX_READINGS = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [irpwd_pkg::CfgAw-1:0] cfg_addr_i,
  input  wire logic [irpwd_pkg::CfgDw-1:0] cfg_wdata_i,
  // input stream
  input  wire logic                        s_axis_tvalid_i,
  output      logic                        s_axis_tready_o,
  input  wire logic [irpwd_pkg::InDw-1:0]  s_axis_tdata_i,  // [0] pin_level
  // result stream
  output      logic                        m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output      logic [irpwd_pkg::OutDw-1:0] m_axis_tdata_o   // code, status, reading_count
);
  import irpwd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_READINGS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_READINGS);

  // Configuration registers
  logic [TolW-1:0] tol_q;
  logic [DurW-1:0] timeout_q, hdr_mark_q, hdr_space_q, skip_q, zero_q, one_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= TolW'(200);
      timeout_q   <= DurW'(15000);
      hdr_mark_q  <= DurW'(9000);
      hdr_space_q <= DurW'(4500);
      skip_q      <= DurW'(550);
      zero_q      <= DurW'(600);
      one_q       <= DurW'(1600);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_TOLERANCE:    tol_q       <= cfg_wdata_i[TolW-1:0];
        CFG_TIMEOUT:      timeout_q   <= cfg_wdata_i;
        CFG_HEADER_MARK:  hdr_mark_q  <= cfg_wdata_i;
        CFG_HEADER_SPACE: hdr_space_q <= cfg_wdata_i;
        CFG_SKIP_LENGTH:  skip_q      <= cfg_wdata_i;
        CFG_ZERO_SPACE:   zero_q      <= cfg_wdata_i;
        CFG_ONE_SPACE:    one_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Burst state
  logic             in_burst_q, in_burst_d;
  logic             level_q, level_d;
  logic [DurW-1:0]  run_q, run_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CodeW-1:0] code_q, code_d;
  logic             hdr_ok_q, hdr_ok_d;
  logic             bad_q, bad_d;

  // Output slots
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  logic    accept, pin, res_valid;
  result_t res;

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pin             = s_axis_tdata_i[0];

  // Per-item datapath
  logic [DurW-1:0]   run_inc;
  logic [DurW:0]     dur;
  logic [CntW-1:0]   idx_inc, idx_f;
  logic [CountW-1:0] idx_ext, idx_f_ext;
  logic              lvl_change, is0, is1, odd;
  logic              win0, win1;

  always_comb begin
    run_inc    = (run_q != '1) ? run_q + DurW'(1) : run_q;
    dur        = {1'b0, run_inc} + (DurW+1)'(1);
    lvl_change = pin != level_q;
    idx_inc    = idx_q + CntW'(1);
    idx_ext    = CountW'(idx_q);
    is0        = idx_q == '0;
    is1        = idx_q == CntW'(1);
    odd        = idx_q[0];
    win0       = dur_in_window(zero_q, dur, tol_q);
    win1       = dur_in_window(one_q, dur, tol_q);

    in_burst_d = in_burst_q;
    level_d    = level_q;
    run_d      = run_q;
    idx_d      = idx_q;
    code_d     = code_q;
    hdr_ok_d   = hdr_ok_q;
    bad_d      = bad_q;
    res_valid  = 1'b0;
    idx_f      = idx_q;

    if (!in_burst_q) begin
      // idle: a low sample opens a burst
      if (!pin) begin
        in_burst_d = 1'b1;
        level_d    = 1'b0;
        run_d      = '0;
        idx_d      = '0;
        code_d     = '0;
        hdr_ok_d   = 1'b0;
        bad_d      = 1'b0;
      end
    end else if (lvl_change) begin
      // run ended: judge its duration
      if (is0) begin
        hdr_ok_d = dur_near(hdr_mark_q, dur, tol_q);
      end else if (is1) begin
        hdr_ok_d = hdr_ok_q && dur_near(hdr_space_q, dur, tol_q);
      end else if (!odd) begin
        if (!dur_near(skip_q, dur, tol_q)) bad_d = 1'b1;
      end else if (!win0) begin
        if (win1) begin
          if (idx_ext < CountW'(64)) code_d[idx_ext[5:1]] = 1'b1;
        end else begin
          bad_d = 1'b1;
        end
      end
      idx_d   = idx_inc;
      idx_f   = idx_inc;
      run_d   = '0;
      level_d = !level_q;
      if (idx_inc >= MaxCnt) res_valid = 1'b1;
    end else begin
      run_d = run_inc;
      if (run_inc >= timeout_q) res_valid = 1'b1;
    end

    if (res_valid) in_burst_d = 1'b0;

    // result fields
    idx_f_ext         = CountW'(idx_f);
    res.reading_count = idx_f_ext;
    res.code          = '0;
    if (idx_f_ext < CountW'(2) || !hdr_ok_d) begin
      res.status = ST_NOISE;
    end else if (idx_f_ext <= CountW'(4) || bad_d) begin
      res.status = ST_MALFORMED;
    end else begin
      res.status = ST_OK;
      res.code   = code_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_burst_q <= 1'b0;
      level_q    <= 1'b0;
      run_q      <= '0;
      idx_q      <= '0;
      code_q     <= '0;
      hdr_ok_q   <= 1'b0;
      bad_q      <= 1'b0;
    end else if (accept) begin
      in_burst_q <= in_burst_d;
      level_q    <= level_d;
      run_q      <= run_d;
      idx_q      <= idx_d;
      code_q     <= code_d;
      hdr_ok_q   <= hdr_ok_d;
      bad_q      <= bad_d;
    end
  end

  // Two-slot result buffer
  logic pop, push;
  assign pop  = out_valid_q && m_axis_tready_i;
  assign push = accept && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (out_valid_q && !pop) skid_q <= res;
      else out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDw'({out_q.reading_count, out_q.status, out_q.code});

endmodule

`default_nettype wire

/* hw/rtl/irpwd_checker.sv */
// Checker: port-level properties of the IR pulse-width decoder, bound to the top level.
`default_nettype none

module irpwd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        m_axis_tvalid_o,
  input wire logic                        m_axis_tready_i,
  input wire logic [irpwd_pkg::OutDw-1:0] m_axis_tdata_o
);
  import irpwd_pkg::*;

  logic [StatW-1:0]  stat;
  logic [CountW-1:0] cnt;
  assign stat = m_axis_tdata_o[CodeW+StatW-1:CodeW];
  assign cnt  = m_axis_tdata_o[CodeW+StatW+CountW-1:CodeW+StatW];

  // a stalled result item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result item changed while stalled");

  // only defined status codes
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (stat == ST_OK || stat == ST_NOISE || stat == ST_MALFORMED))
    else $error("undefined status code");

  // a failed burst carries no code
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && stat != ST_OK |-> m_axis_tdata_o[CodeW-1:0] == '0)
    else $error("nonzero code on failed burst");

  // an ok burst has header plus more than two data readings
  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && stat == ST_OK |-> cnt > CountW'(4))
    else $error("ok status with too few readings");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OutDw-1:CodeW+StatW+CountW] == '0)
    else $error("padding bits set");

endmodule

bind ir_pulse_width_decoder_top irpwd_checker u_irpwd_checker (.*);

`default_nettype wire

/* test/testbench.sv */
// Testbench for the IR pulse-width decoder: pin-sample bursts in, decoded results checked.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import irpwd_pkg::*;

  localparam int MaxReadings = 256;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  cfg_idx_e          cfg_addr;
  logic [CfgDw-1:0]  cfg_wdata;
  logic              s_tvalid;
  logic              s_tready;
  logic [InDw-1:0]   s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OutDw-1:0]  m_tdata;

  ir_pulse_width_decoder_top #(
    .MAX_READINGS(MaxReadings)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),   // [0] pin_level, [7:1] zero
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)    // [31:0] code, [33:32] status, [42:34] reading_count
  );

  always #10ns clk_i = ~clk_i;

  // Run state shared by stimulus and checker
  bit      gaps_on = 1'b1;
  int      rx_hold_cycles = 0;
  int      fail_count = 0;
  int      samples_sent = 0;
  int      results_seen = 0;
  int      settings_loaded = 0;

  // Decoder prediction: register copies and burst state
  logic [TolW-1:0] cfg_tol;
  logic [DurW-1:0] cfg_timeout, cfg_mark, cfg_space, cfg_skip, cfg_zero, cfg_one;
  bit              burst_active, level_now, hdr_good, bad_burst;
  logic [DurW-1:0] run_len;
  int              reading_num;
  logic [CodeW-1:0] code_bits;
  result_t         expected_results[$];

  // |centre - dur| strictly below tolerance
  function automatic bit within_tol(int centre, int dur);
    int diff;
    diff = (centre > dur) ? centre - dur : dur - centre;
    return diff < int'(cfg_tol);
  endfunction

  // inclusive bit window, lower edge floored at zero
  function automatic bit in_bit_window(int centre, int dur);
    int t, lo;
    t  = int'(cfg_tol);
    lo = (centre > t) ? centre - t : 0;
    return (dur >= lo) && (dur <= centre + t);
  endfunction

  function automatic void judge_reading(int dur);
    if (reading_num == 0) begin
      hdr_good = within_tol(int'(cfg_mark), dur);
    end else if (reading_num == 1) begin
      hdr_good = hdr_good && within_tol(int'(cfg_space), dur);
    end else if (reading_num % 2 == 0) begin
      if (!within_tol(int'(cfg_skip), dur)) bad_burst = 1'b1;
    end else if (!in_bit_window(int'(cfg_zero), dur)) begin
      if (in_bit_window(int'(cfg_one), dur)) begin
        // bits past 31 fall off the end of the code
        if (reading_num / 2 <= 31) code_bits[reading_num / 2] = 1'b1;
      end else begin
        bad_burst = 1'b1;
      end
    end
  endfunction

  function automatic void emit_result();
    result_t r;
    r.code = '0;
    if (reading_num < 2 || !hdr_good) begin
      r.status = ST_NOISE;
    end else if (reading_num <= 4 || bad_burst) begin
      r.status = ST_MALFORMED;
    end else begin
      r.status = ST_OK;
      r.code   = code_bits;
    end
    r.reading_count = CountW'(reading_num);
    expected_results.push_back(r);
    burst_active = 1'b0;
  endfunction

  // advance the predicted decoder by one accepted pin sample
  function automatic void decoder_step(bit pin);
    if (!burst_active) begin
      if (!pin) begin
        burst_active = 1'b1;
        level_now    = 1'b0;
        run_len      = '0;
        reading_num  = 0;
        code_bits    = '0;
        hdr_good     = 1'b0;
        bad_burst    = 1'b0;
      end
      return;
    end
    if (run_len != 16'hFFFF) run_len++;
    if (pin != level_now) begin
      judge_reading(int'(run_len) + 1);
      reading_num++;
      run_len   = '0;
      level_now = !level_now;
      if (reading_num >= MaxReadings) emit_result();
    end else if (run_len >= cfg_timeout) begin
      emit_result();
    end
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [CfgDw-1:0] v);
    case (idx)
      CFG_TOLERANCE:    cfg_tol     = v[TolW-1:0];
      CFG_TIMEOUT:      cfg_timeout = v;
      CFG_HEADER_MARK:  cfg_mark    = v;
      CFG_HEADER_SPACE: cfg_space   = v;
      CFG_SKIP_LENGTH:  cfg_skip    = v;
      CFG_ZERO_SPACE:   cfg_zero    = v;
      CFG_ONE_SPACE:    cfg_one     = v;
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Result side: random ready gaps, long hold-off on request, checks each item
  int rx_wait = 0;
  always @(posedge clk_i) begin : result_monitor
    result_t got, want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %0h",
                   $time, got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("code", want.code, got.code);
          compare_field("status", want.status, got.status);
          compare_field("reading_count", want.reading_count, got.reading_count);
        end
        rx_wait = gaps_on ? $urandom_range(0, 3) : 0;
      end else if (!m_tvalid && gaps_on && $urandom_range(0, 7) == 0) begin
        rx_wait = $urandom_range(1, 3);
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        m_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Send one pin sample; predict once the block takes it
  task automatic send_pin(input bit pin);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDw-1){1'b0}}, pin};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    decoder_step(pin);
    samples_sent++;
  endtask

  // hold the current level until the burst times out
  task automatic end_with_timeout();
    while (burst_active) send_pin(level_now);
  endtask

  // burst of readings with the given durations (each >= 2), then a timeout
  task automatic send_frame(input int durs[$]);
    bit lvl;
    lvl = 1'b0;
    foreach (durs[i]) begin
      repeat (durs[i] - 1) send_pin(lvl);
      lvl = !lvl;
    end
    // the level change closes the last reading
    send_pin(lvl);
    end_with_timeout();
  endtask

  // drop valid, let every expected result drain, then let the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CfgDw'(value);
    @(posedge clk_i);
    apply_reg(idx, CfgDw'(value));
  endtask

  task automatic write_config(input int tol_v, input int tmo_v, input int mark_v,
                              input int space_v, input int skip_v, input int zero_v,
                              input int one_v);
    wait_idle();
    write_reg(CFG_TOLERANCE, tol_v);
    write_reg(CFG_TIMEOUT, tmo_v);
    write_reg(CFG_HEADER_MARK, mark_v);
    write_reg(CFG_HEADER_SPACE, space_v);
    write_reg(CFG_SKIP_LENGTH, skip_v);
    write_reg(CFG_ZERO_SPACE, zero_v);
    write_reg(CFG_ONE_SPACE, one_v);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    settings_loaded++;
  endtask

  // random durations around a centre: strictly inside tolerance / inside window
  function automatic int near_dur(int centre);
    int t, d;
    t = int'(cfg_tol);
    d = (t == 0) ? centre : centre + int'($urandom_range(0, 2 * (t - 1))) - (t - 1);
    return (d < 2) ? 2 : d;
  endfunction

  function automatic int window_dur(int centre);
    int t, d;
    t = int'(cfg_tol);
    d = centre + int'($urandom_range(0, 2 * t)) - t;
    return (d < 2) ? 2 : d;
  endfunction

  // Reset register values: short readings cut at the reading limit, no header
  task automatic test_reset_values();
    int durs[$];
    gaps_on = 1'b0;
    repeat (MaxReadings) durs.push_back(2);
    send_frame(durs);
  endtask

  // Timeouts before the header, header edges, short and broken bursts
  task automatic test_header_cases();
    gaps_on = 1'b1;
    write_config(2, 12, 8, 6, 3, 3, 7);
    send_pin(1'b0);
    end_with_timeout();
    send_frame('{8});
    send_frame('{8, 6});
    send_frame('{8, 6, 3, 3});
    send_frame('{10, 6, 3, 3, 3});
    send_frame('{9, 7, 3, 7, 3});
    send_frame('{8, 6, 5, 3, 3});
    send_frame('{8, 5, 2, 8, 4, 3, 3, 7});
  endtask

  // Bit windows incl. floored lower edge, inclusive upper edge, misses
  task automatic test_bit_windows();
    write_config(3, 20, 10, 8, 4, 2, 12);
    send_frame('{10, 8, 4, 2, 4, 5, 4, 9, 4, 15, 4});
    send_frame('{10, 8, 4, 6, 4});
    send_frame('{10, 8, 4, 16, 4});
    send_frame('{10, 8, 4, 12, 4, 2, 2});
  endtask

  // Burst cut at the reading limit, code bits past 31, zero and unit timeout
  task automatic test_reading_limit();
    int durs[$];
    write_config(1, 6, 3, 3, 2, 2, 4);
    durs = '{3, 3};
    repeat (127) begin
      durs.push_back(2);
      durs.push_back($urandom_range(0, 1) ? 4 : 2);
    end
    send_frame(durs);
    write_config(1, 0, 3, 3, 2, 2, 4);
    repeat (30) send_pin($urandom_range(0, 1));
    end_with_timeout();
    write_config(0, 1, 0, 0, 0, 0, 0);
    repeat (30) send_pin($urandom_range(0, 1));
    end_with_timeout();
  endtask

  // Widest register values: full tolerance, windows floored at zero, longest timeout
  task automatic test_wide_settings();
    int durs[$];
    gaps_on = 1'b0;
    write_config(4095, 65535, 0, 0, 0, 0, 65535);
    repeat (MaxReadings) durs.push_back($urandom_range(2, 3));
    send_frame(durs);
    gaps_on = 1'b1;
  endtask

  // Receiver holds off while a result comes every two samples
  task automatic test_output_backpressure();
    write_config(2, 0, 8, 6, 3, 3, 7);
    rx_hold_cycles = 300;
    repeat (80) send_pin(1'b0);
    end_with_timeout();
  endtask

  // Mostly well-formed frames with random content, some noise, new settings
  task automatic test_random_bursts();
    int start_samples, nburst, nbits, pos, t, top;
    int durs[$];
    start_samples = samples_sent;
    nburst = 0;
    while (samples_sent - start_samples < 500) begin
      if (nburst % 6 == 0) begin
        t = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
        durs = '{$urandom_range(6, 20), $urandom_range(4, 12), $urandom_range(2, 6),
                 $urandom_range(1, 6)};
        durs.push_back(durs[3] + $urandom_range(0, 2 * t + 3));
        top = durs.max()[0];
        write_config(t, top + t + $urandom_range(0, 6), durs[0], durs[1], durs[2],
                     durs[3], durs[4]);
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        durs = '{near_dur(int'(cfg_mark)), near_dur(int'(cfg_space))};
        nbits = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
        repeat (nbits) begin
          durs.push_back(near_dur(int'(cfg_skip)));
          durs.push_back(window_dur($urandom_range(0, 1) ? int'(cfg_one) : int'(cfg_zero)));
        end
        if ($urandom_range(0, 1)) durs.push_back(near_dur(int'(cfg_skip)));
        // occasionally break one reading
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, durs.size() - 1);
          durs[pos] = $urandom_range(2, int'(cfg_timeout) + 1);
        end
        send_frame(durs);
      end else begin
        repeat ($urandom_range(1, 40)) send_pin($urandom_range(0, 1));
        end_with_timeout();
      end
      repeat ($urandom_range(0, 3)) send_pin(1'b1);
      nburst++;
    end
  endtask

  initial begin : main_sequence
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_TOLERANCE;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    m_tready  <= 1'b0;
    cfg_tol = 200; cfg_timeout = 15000; cfg_mark = 9000; cfg_space = 4500;
    cfg_skip = 550; cfg_zero = 600; cfg_one = 1600;
    burst_active = 1'b0; level_now = 1'b0; hdr_good = 1'b0; bad_burst = 1'b0;
    run_len = '0; reading_num = 0; code_bits = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_header_cases();
    test_bit_windows();
    test_reading_limit();
    test_wide_settings();
    test_output_backpressure();
    test_random_bursts();

    wait_idle();
    $display("Sent %0d pin samples and checked %0d burst results", samples_sent, results_seen);
    $display("across %0d register settings plus the reset values", settings_loaded);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : run_limit
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

/* ir_pulse_width_decoder_top.f */
hw/rtl/irpwd_pkg.sv
hw/rtl/ir_pulse_width_decoder_top.sv
hw/rtl/irpwd_checker.sv
test/testbench.sv
